FILE: src/tfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_pkg
// shared constants, operation codes and the request record that moves down
// the translation buffer cell chain
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_BITS   = 8;
  localparam int FRAME_COUNT = 128;

  localparam int IDX_W   = $clog2(TLB_ENTRIES);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;

  // one request in flight, plus its partial result
  typedef struct packed {
    logic                 valid;
    logic [FUNC_W-1:0]    func;
    logic [PAGE_BITS-1:0] page;
    logic [FRAME_W-1:0]   frame;
    logic [IDX_W-1:0]     slot;   // target slot of an add
    logic                 hit;
    logic [IDX_W-1:0]     index;
  } stage_t;

endpackage
`default_nettype wire

FILE: src/tfr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_req_if
// request channel: operation, page and frame with valid/ready
// ----------------------------------------------------------------------------
interface tfr_req_if;
  logic                          valid;
  logic                          ready;
  logic [tfr_pkg::FUNC_W-1:0]    func;
  logic [tfr_pkg::PAGE_BITS-1:0] page_number;
  logic [tfr_pkg::FRAME_W-1:0]   frame_number;

  modport source (output valid, func, page_number, frame_number, input ready);
  modport sink   (input valid, func, page_number, frame_number, output ready);
endinterface
`default_nettype wire

FILE: src/tfr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_rsp_if
// result channel: hit flag and entry index with valid/ready
// ----------------------------------------------------------------------------
interface tfr_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [tfr_pkg::IDX_W-1:0] entry_index;

  modport source (output valid, hit, entry_index, input ready);
  modport sink   (input valid, hit, entry_index, output ready);
endinterface
`default_nettype wire

FILE: src/tfr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_cell
// one translation entry: compares the passing request, applies add or
// update to its own entry and registers the request for the next cell
// ----------------------------------------------------------------------------
module tfr_cell (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        adv,
  input  wire [tfr_pkg::IDX_W-1:0]   cell_idx,
  input  wire tfr_pkg::stage_t       stage_in,
  output tfr_pkg::stage_t            stage_out
);

  logic [tfr_pkg::PAGE_BITS-1:0] entry_page;
  logic [tfr_pkg::FRAME_W-1:0]   entry_frame;
  logic                          entry_valid;

  logic            match;
  logic            do_add;
  logic            do_update;
  tfr_pkg::stage_t stage_next;

  // only the first matching cell claims the request
  assign match = stage_in.valid && entry_valid && !stage_in.hit
                 && (entry_page == stage_in.page);
  assign do_add = stage_in.valid && (stage_in.func == tfr_pkg::FUNC_ADD)
                  && (stage_in.slot == cell_idx);
  assign do_update = match && (stage_in.func == tfr_pkg::FUNC_UPDATE);

  always_comb begin
    stage_next = stage_in;
    if (match && ((stage_in.func == tfr_pkg::FUNC_LOOKUP) ||
                  (stage_in.func == tfr_pkg::FUNC_UPDATE))) begin
      stage_next.hit   = 1'b1;
      stage_next.index = cell_idx;
    end
  end

  // only the valid bits need a reset; data fields hold through it
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid     <= 1'b0;
      stage_out.valid <= 1'b0;
    end else if (adv) begin
      stage_out <= stage_next;
      if (do_add) begin
        entry_valid <= 1'b1;
        entry_page  <= stage_in.page;
        entry_frame <= stage_in.frame;
      end else if (do_update) begin
        entry_frame <= stage_in.frame;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/tlb_fifo_replacement.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_fifo_replacement
// fully associative translation buffer with first-in first-out replacement
// ----------------------------------------------------------------------------
// usage:
//   req carries one request: lookup, add at the oldest slot, or frame update
//   rsp returns exactly one result per request, in request order
//   the entries sit in a row of cells; a request walks the row one cell per
//   cycle unless the row is frozen; every cell compares it with its own entry
//   and the first valid match claims it, so the lowest matching slot wins
//   an add gets its target slot from the oldest-slot pointer when accepted
//   result: a request is registered by every cell of the row in turn, and the
//   last cell's register is the output register
//   throughput: one request per cycle while rsp is not stalled; the row is a
//   pipeline and holds up to TLB_ENTRIES requests at once
//   stall: when rsp is valid and not ready the whole row freezes and
//   req.ready drops, so the result holds and nothing is lost
//   reset: all entries become empty, the pointer returns to slot zero and
//   the row is flushed; no clearing pass is needed
// ----------------------------------------------------------------------------
module tlb_fifo_replacement (
  input  wire        clk,
  input  wire        rst,
  tfr_req_if.sink    req,
  tfr_rsp_if.source  rsp
);

  localparam int N = tfr_pkg::TLB_ENTRIES;

  // stage[i] feeds cell i; stage[N] is the result register
  tfr_pkg::stage_t stage [0:N];

  logic                      adv;
  logic                      accept;
  logic [tfr_pkg::IDX_W-1:0] oldest_slot;
  logic [tfr_pkg::IDX_W-1:0] oldest_slot_next;

  // the row moves unless a finished result is waiting
  assign adv    = !(stage[N].valid && !rsp.ready);
  assign accept = req.valid && adv;
  assign req.ready = adv;

  // head of the row: a fresh request with no hit; an add carries its slot as index
  always_comb begin
    stage[0].valid = accept;
    stage[0].func  = req.func;
    stage[0].page  = req.page_number;
    stage[0].frame = req.frame_number;
    stage[0].slot  = oldest_slot;
    stage[0].hit   = 1'b0;
    stage[0].index = (req.func == tfr_pkg::FUNC_ADD) ? oldest_slot : '0;
  end

  // fifo pointer, wraps after the last slot
  always_comb begin
    oldest_slot_next = oldest_slot;
    if (accept && (req.func == tfr_pkg::FUNC_ADD)) begin
      if (oldest_slot == tfr_pkg::IDX_W'(N - 1)) begin
        oldest_slot_next = '0;
      end else begin
        oldest_slot_next = oldest_slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot <= '0;
    end else begin
      oldest_slot <= oldest_slot_next;
    end
  end

  // the row of entry cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    tfr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cell_idx  (tfr_pkg::IDX_W'(i)),
      .stage_in  (stage[i]),
      .stage_out (stage[i+1])
    );
  end

  // the last cell's register is the output register
  assign rsp.valid       = stage[N].valid;
  assign rsp.hit         = stage[N].hit;
  assign rsp.entry_index = stage[N].index;

endmodule
`default_nettype wire

FILE: src/tfr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfr_checker
// port-level checks for the translation buffer, bound to the top level
// ----------------------------------------------------------------------------
module tfr_checker (
  input wire                      clk,
  input wire                      rst,
  input wire                      in_valid,
  input wire                      in_ready,
  input wire                      out_valid,
  input wire                      out_ready,
  input wire                      out_hit,
  input wire [tfr_pkg::IDX_W-1:0] out_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_index))
    else $error("result changed while stalled");

  // reset empties the row
  a_rst_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  // requests are refused only while a result waits
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == !(out_valid && !out_ready))
    else $error("request ready does not follow result stall");

  // a request is refused only while a result is shown
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid)
    else $error("request refused with no result waiting");

endmodule

bind tlb_fifo_replacement tfr_checker u_tfr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_hit   (rsp.hit),
  .out_index (rsp.entry_index)
);
`default_nettype wire
